// ----- rtl/stl_pkg.sv -----
`default_nettype none

package stl_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int Q_BITS        = 30;
    localparam int LIN_W         = 31;
    localparam int T_W           = 31;
    localparam int F_W           = 31;
    localparam int COEF_W        = 24;
    localparam int PROD_W        = COEF_W + LIN_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int LNUM_W        = 47;
    localparam int LAB_W         = 42;
    localparam int ROUND_SHIFT   = Q_BITS - FRACTION_BITS;

    localparam longint LMAX_RAW  = longint'(100) << FRACTION_BITS;
    localparam longint LMAX      = (LMAX_RAW > 32767) ? 32767 : LMAX_RAW;

    localparam longint unsigned ONE_Q = longint'(1) << Q_BITS;

    // Matrix rows scaled by 1e7: X, Y, Z, each column R, G, B.
    localparam logic [COEF_W-1:0] COEF [3][3] = '{
        '{24'd4124564, 24'd3575761, 24'd1804375},
        '{24'd2126729, 24'd7151522, 24'd721750},
        '{24'd193339,  24'd1191920, 24'd9503041}
    };

    // White point divisors on the same 1e7 scale.
    localparam logic [COEF_W:0] WHITE_DIV [3] = '{25'd9504890, 25'd10000000, 25'd10888400};

    // The white point division takes the top 32 bits of the rounded sum (below 2^54)
    // times floor(2^55 / D); the estimate is low by at most one.
    localparam int DIV_IN_LSB  = 22;
    localparam int DIV_IN_W    = 32;
    localparam int RECIP_EXP   = 55;
    localparam int RECIP_SHIFT = RECIP_EXP - DIV_IN_LSB;
    localparam int REM_W       = 26;

    localparam logic [31:0] WHITE_RECIP [3] = '{
        32'((64'd1 << RECIP_EXP) / 64'd9504890),
        32'((64'd1 << RECIP_EXP) / 64'd10000000),
        32'((64'd1 << RECIP_EXP) / 64'd10888400)
    };

    localparam logic [LNUM_W-1:0] LAB_SLOPE   = 47'd24389;
    localparam logic [LNUM_W-1:0] LAB_KNEE    = 47'd216 << Q_BITS;
    localparam logic [LNUM_W-1:0] LAB_OFFSET  = (47'd432 << Q_BITS) + 47'd1566;
    localparam logic [LNUM_W-1:0] LAB_DIV     = 47'd3132;

    // On the linear segment the numerator stays below 2^40; its top 32 bits times
    // floor(2^43 / 3132) give a quotient low by at most one.
    localparam int LAB_IN_LSB      = 8;
    localparam int LAB_IN_W        = 32;
    localparam int LAB_RECIP_EXP   = 43;
    localparam int LAB_RECIP_SHIFT = LAB_RECIP_EXP - LAB_IN_LSB;
    localparam int LREM_W          = 14;

    localparam logic [31:0] LAB_RECIP = 32'((64'd1 << LAB_RECIP_EXP) / 64'd3132);

    typedef logic [LIN_W-1:0] lin_tab_t [256];

    function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
        return (a * b) >> Q_BITS;
    endfunction

    function automatic longint unsigned pow5(longint unsigned y);
        longint unsigned s;
        s = qmul(y, y);
        s = qmul(s, y);
        s = qmul(s, y);
        return qmul(s, y);
    endfunction

    // sRGB transfer curve for one code, with the power taken by a fifth-root search.
    function automatic logic [LIN_W-1:0] lin_value(int unsigned c);
        longint unsigned cc;
        longint unsigned v;
        longint unsigned v2;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        cc = longint'(c);
        if (cc <= 10)
        begin
            return LIN_W'((10 * cc * ONE_Q + 16473) / 32946);
        end
        v  = ((1000 * cc + 14025) * ONE_Q + 134512) / 269025;
        v2 = qmul(v, v);
        lo = 0;
        hi = ONE_Q;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            if (pow5(mid) <= v2)
            begin
                lo = mid;
            end
            else
            begin
                hi = mid - 1;
            end
        end
        return LIN_W'(qmul(v2, lo));
    endfunction

    function automatic lin_tab_t build_lin_tab();
        lin_tab_t tab;
        for (int i = 0; i < 256; i++)
        begin
            tab[i] = lin_value(i);
        end
        return tab;
    endfunction

    localparam lin_tab_t LIN_TAB = build_lin_tab();

    // Round to the output fraction, half away from zero.
    function automatic logic signed [LAB_W-1:0] round_frac(logic signed [LAB_W-1:0] v);
        logic [LAB_W-1:0] mag;
        logic [LAB_W-1:0] r;
        mag = v[LAB_W-1] ? LAB_W'(-v) : LAB_W'(v);
        r   = (mag + (LAB_W'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
        return v[LAB_W-1] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [LAB_W-1:0] clamp(logic signed [LAB_W-1:0] v,
                                                      logic signed [LAB_W-1:0] lo,
                                                      logic signed [LAB_W-1:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/srgb_to_cielab.sv -----
`default_nettype none

// sRGB to CIE L*a*b* (D65) converter, fully pipelined.
// Request channel: red, green, blue are taken at a rising edge with start high
// and busy low. busy is always low, so one pixel may be sent every clock.
// Result channel: done is high for one cycle together with lightness,
// green_red_axis and blue_yellow_axis, after the request has passed every stage;
// the result is taken at the rising edge that ends that cycle.
// Throughput is one pixel per cycle; the latency is set mostly by the cube-root
// search, 31 stages of one bit each after a setup stage.
// Linearization is a 256-entry constant table, followed by one product stage
// and one sum stage. Division by the white point takes three stages: a
// reciprocal estimate, a remainder and a correction. The linear segment of the
// Lab curve is divided the same way during the first stages of the root search.
// Two more stages form and round the Lab values.
// The receiver cannot stall; results are always presented and then dropped.
// Reset clears all valid bits, so nothing in flight survives it and done
// stays low until a new request has passed through.
module srgb_to_cielab
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [7:0]         red,
    input  wire logic [7:0]         green,
    input  wire logic [7:0]         blue,
    output logic                    done,
    output logic [14:0]             lightness,
    output logic signed [15:0]      green_red_axis,
    output logic signed [15:0]      blue_yellow_axis
);

    localparam int DIV_STEPS  = 3;
    localparam int ROOT_STEPS = stl_pkg::F_W;
    localparam int LATENCY    = DIV_STEPS + ROOT_STEPS + 6;
    localparam int SQ_W       = 2 * stl_pkg::F_W;
    localparam int W          = stl_pkg::LAB_W;

    logic                          a_vld_reg;
    logic [stl_pkg::LIN_W-1:0]     lin_reg [3];
    logic                          b_vld_reg;
    logic [stl_pkg::PROD_W-1:0]    prod_reg [3][3];

    logic                          dv_vld_reg  [DIV_STEPS+1];
    logic [stl_pkg::SUM_W-1:0]     dv_sum_reg  [3];
    logic [stl_pkg::T_W-1:0]       dv_est_reg  [3];
    logic [stl_pkg::T_W-1:0]       dv_est_next [3];
    logic [stl_pkg::REM_W-1:0]     dv_low_reg  [3];
    logic [stl_pkg::T_W-1:0]       dv_base_reg [3];
    logic [stl_pkg::REM_W-1:0]     dv_rem_reg  [3];
    logic [stl_pkg::REM_W-1:0]     dv_rem_next [3];
    logic [stl_pkg::T_W-1:0]       dv_t_reg    [3];
    logic [stl_pkg::T_W-1:0]       dv_t_next   [3];

    logic                          rt_vld_reg  [ROOT_STEPS+1];
    logic [stl_pkg::T_W-1:0]       rt_t_reg    [ROOT_STEPS+1][3];
    logic [stl_pkg::F_W-1:0]       rt_y_reg    [ROOT_STEPS+1][3];
    logic [stl_pkg::F_W-1:0]       rt_y_next   [ROOT_STEPS+1][3];
    logic [SQ_W-1:0]               rt_sq_reg   [ROOT_STEPS+1][3];
    logic [SQ_W-1:0]               rt_sq_next  [ROOT_STEPS+1][3];
    logic [stl_pkg::LNUM_W-1:0]    rt_n_reg    [ROOT_STEPS+1][3];
    logic [stl_pkg::LNUM_W-1:0]    rt_n_next   [ROOT_STEPS+1][3];
    logic [stl_pkg::F_W-1:0]       rt_ql_reg   [ROOT_STEPS+1][3];
    logic [stl_pkg::F_W-1:0]       rt_ql_next  [ROOT_STEPS+1][3];
    logic                          rt_sel_reg  [ROOT_STEPS+1][3];

    logic                          lab_vld_reg;
    logic signed [W-1:0]           lq_reg;
    logic signed [W-1:0]           aq_reg;
    logic signed [W-1:0]           bq_reg;

    logic                          done_reg;
    logic [14:0]                   light_reg;
    logic signed [15:0]            gr_reg;
    logic signed [15:0]            by_reg;

    logic                          accept;
    logic [stl_pkg::LNUM_W-1:0]    t_scaled [3];
    logic signed [W-1:0]           f_s [3];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Division by the white point: reciprocal estimate, remainder, then one correction.
    always_comb
    begin
        logic [63:0] est_prod;
        for (int c = 0; c < 3; c++)
        begin
            est_prod = 64'(dv_sum_reg[c][stl_pkg::DIV_IN_LSB +: stl_pkg::DIV_IN_W])
                       * 64'(stl_pkg::WHITE_RECIP[c]);
            dv_est_next[c] = stl_pkg::T_W'(est_prod >> stl_pkg::RECIP_SHIFT);
            dv_rem_next[c] = dv_low_reg[c]
                             - stl_pkg::REM_W'(dv_est_reg[c] * stl_pkg::WHITE_DIV[c]);
            dv_t_next[c]   = dv_base_reg[c]
                             + stl_pkg::T_W'(dv_rem_reg[c] >= stl_pkg::REM_W'(stl_pkg::WHITE_DIV[c]));
        end
    end

    // Cube-root search with an exact running square. The linear segment is divided
    // beside it: an estimate in the first stage, the remainder in the second and
    // the correction in the third; the quotient then rides along.
    always_comb
    begin
        logic [stl_pkg::F_W-1:0]    yc;
        logic [SQ_W-1:0]            sqc;
        logic [2*stl_pkg::F_W:0]    prod;
        logic [63:0]                lprod;
        logic [stl_pkg::LREM_W-1:0] lrem;
        int                         k;
        for (int i = 0; i <= ROOT_STEPS; i++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                rt_y_next[i][c]  = rt_y_reg[i][c];
                rt_sq_next[i][c] = rt_sq_reg[i][c];
                rt_n_next[i][c]  = rt_n_reg[i][c];
                rt_ql_next[i][c] = rt_ql_reg[i][c];
                if (i < ROOT_STEPS)
                begin
                    k    = ROOT_STEPS - 1 - i;
                    yc   = rt_y_reg[i][c] | (stl_pkg::F_W'(1) << k);
                    sqc  = rt_sq_reg[i][c] + (SQ_W'(rt_y_reg[i][c]) << (k + 1))
                           + (SQ_W'(1) << (2 * k));
                    prod = (2*stl_pkg::F_W+1)'(sqc[SQ_W-1:stl_pkg::Q_BITS])
                           * (2*stl_pkg::F_W+1)'(yc);
                    if (prod[2*stl_pkg::F_W:stl_pkg::Q_BITS]
                        <= (2*stl_pkg::F_W+1-stl_pkg::Q_BITS)'(rt_t_reg[i][c]))
                    begin
                        rt_y_next[i][c]  = yc;
                        rt_sq_next[i][c] = sqc;
                    end
                end
                if (i == 0)
                begin
                    lprod = 64'(rt_n_reg[i][c][stl_pkg::LAB_IN_LSB +: stl_pkg::LAB_IN_W])
                            * 64'(stl_pkg::LAB_RECIP);
                    rt_ql_next[i][c] = stl_pkg::F_W'(lprod >> stl_pkg::LAB_RECIP_SHIFT);
                end
                else if (i == 1)
                begin
                    lrem = stl_pkg::LREM_W'(rt_n_reg[i][c])
                           - stl_pkg::LREM_W'(rt_ql_reg[i][c]
                                              * stl_pkg::LREM_W'(stl_pkg::LAB_DIV));
                    rt_n_next[i][c] = stl_pkg::LNUM_W'(lrem);
                end
                else if (i == 2)
                begin
                    if (rt_n_reg[i][c] >= stl_pkg::LAB_DIV)
                    begin
                        rt_ql_next[i][c] = rt_ql_reg[i][c] + stl_pkg::F_W'(1);
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            t_scaled[c] = stl_pkg::LNUM_W'(dv_t_reg[c]) * stl_pkg::LAB_SLOPE;
            f_s[c] = rt_sel_reg[ROOT_STEPS][c] ? W'(rt_y_reg[ROOT_STEPS][c])
                                               : W'(rt_ql_reg[ROOT_STEPS][c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            lab_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
            for (int i = 0; i <= DIV_STEPS; i++)
            begin
                dv_vld_reg[i] <= 1'b0;
            end
            for (int i = 0; i <= ROOT_STEPS; i++)
            begin
                rt_vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            a_vld_reg     <= accept;
            b_vld_reg     <= a_vld_reg;
            dv_vld_reg[0] <= b_vld_reg;
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                dv_vld_reg[i+1] <= dv_vld_reg[i];
            end
            rt_vld_reg[0] <= dv_vld_reg[DIV_STEPS];
            for (int i = 0; i < ROOT_STEPS; i++)
            begin
                rt_vld_reg[i+1] <= rt_vld_reg[i];
            end
            lab_vld_reg <= rt_vld_reg[ROOT_STEPS];
            done_reg    <= lab_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lin_reg[0] <= stl_pkg::LIN_TAB[red];
        lin_reg[1] <= stl_pkg::LIN_TAB[green];
        lin_reg[2] <= stl_pkg::LIN_TAB[blue];
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_reg[r][c] <= stl_pkg::PROD_W'(stl_pkg::COEF[r][c])
                                  * stl_pkg::PROD_W'(lin_reg[c]);
            end
            dv_sum_reg[r] <= stl_pkg::SUM_W'(prod_reg[r][0]) + stl_pkg::SUM_W'(prod_reg[r][1])
                             + stl_pkg::SUM_W'(prod_reg[r][2])
                             + stl_pkg::SUM_W'(stl_pkg::WHITE_DIV[r] >> 1);
        end
        for (int c = 0; c < 3; c++)
        begin
            dv_est_reg[c]  <= dv_est_next[c];
            dv_low_reg[c]  <= dv_sum_reg[c][stl_pkg::REM_W-1:0];
            dv_base_reg[c] <= dv_est_reg[c];
            dv_rem_reg[c]  <= dv_rem_next[c];
            dv_t_reg[c]    <= dv_t_next[c];
        end
        for (int c = 0; c < 3; c++)
        begin
            rt_t_reg[0][c]   <= dv_t_reg[c];
            rt_y_reg[0][c]   <= '0;
            rt_sq_reg[0][c]  <= '0;
            rt_n_reg[0][c]   <= t_scaled[c] + stl_pkg::LAB_OFFSET;
            rt_ql_reg[0][c]  <= '0;
            rt_sel_reg[0][c] <= t_scaled[c] > stl_pkg::LAB_KNEE;
        end
        for (int i = 0; i < ROOT_STEPS; i++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                rt_t_reg[i+1][c]   <= rt_t_reg[i][c];
                rt_y_reg[i+1][c]   <= rt_y_next[i][c];
                rt_sq_reg[i+1][c]  <= rt_sq_next[i][c];
                rt_n_reg[i+1][c]   <= rt_n_next[i][c];
                rt_ql_reg[i+1][c]  <= rt_ql_next[i][c];
                rt_sel_reg[i+1][c] <= rt_sel_reg[i][c];
            end
        end
        lq_reg <= W'(116) * f_s[1] - (W'(16) <<< stl_pkg::Q_BITS);
        aq_reg <= W'(500) * (f_s[0] - f_s[1]);
        bq_reg <= W'(200) * (f_s[1] - f_s[2]);
        light_reg <= 15'(stl_pkg::clamp(stl_pkg::round_frac(lq_reg), '0, W'(stl_pkg::LMAX)));
        gr_reg    <= 16'(stl_pkg::clamp(stl_pkg::round_frac(aq_reg), -W'(32768), W'(32767)));
        by_reg    <= 16'(stl_pkg::clamp(stl_pkg::round_frac(bq_reg), -W'(32768), W'(32767)));
    end

    assign done             = done_reg;
    assign lightness        = light_reg;
    assign green_red_axis   = gr_reg;
    assign blue_yellow_axis = by_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching request");

    a_light_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (15'(lightness) <= 15'(stl_pkg::LMAX)))
        else $error("lightness above range");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised although every request is taken");

endmodule

`default_nettype wire
